// File: hdl/dsds_pkg.sv
// ---------------------------------------------------------------------------
// dsds_pkg: shared types and constants for the descriptor SAD disparity search
// Holds the payload structs, the register indexes, the controller state
// encoding and the command and status bundles that join controller and
// datapath.
// ---------------------------------------------------------------------------
`default_nettype none
package dsds_pkg;
   localparam int MAX_DISP_DEPTH_DEF = 64;
   localparam int DESC_BYTES_DEF     = 32;
   localparam int COORD_BITS_DEF     = 12;
   localparam int WORDS              = 4;
   localparam int DISP_W             = 6;
   localparam int COST_W             = 13;
   localparam int DIM_W              = 13;
   localparam int LIM_W              = 12;
   localparam int CSR_IDX_W          = 3;
   localparam int CSR_DATA_W         = 16;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_DISP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMG_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IMG_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_COL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LAST_COL   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_ROW  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LAST_ROW   = 3'd6;

   typedef struct packed {
      logic [63:0] right_desc_w3;
      logic [63:0] right_desc_w2;
      logic [63:0] right_desc_w1;
      logic [63:0] right_desc_w0;
      logic [63:0] left_desc_w3;
      logic [63:0] left_desc_w2;
      logic [63:0] left_desc_w1;
      logic [63:0] left_desc_w0;
   } req_type;

   typedef struct packed {
      logic [DISP_W-1:0] disparity;
      logic [COST_W-1:0] min_cost;
      logic              end_of_image;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_SCORE,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture accepted word, clear winner track
      logic write;    // store right descriptor in history, latch search setup
      logic rd_issue; // issue history read for current candidate
      logic score;    // compare SAD of registered read data
      logic finish;   // build result, step counters
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic search;   // this pixel runs a candidate search
      logic last_cand;// candidate d has reached 0
   } sts_type;
endpackage
`default_nettype wire

// File: hdl/descriptor_sad_disparity_search.sv
// ---------------------------------------------------------------------------
// descriptor_sad_disparity_search: stereo SAD block matching, winner take all
// Raster-order pixels in, one disparity word out per pixel.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one word per pixel, left and right 32-byte descriptors.
//   rsp_*  : one word per pixel: disparity, min_cost, end_of_image.
//   csr_*  : register writes (index, data); always ready, write while idle.
// Timing:
//   A skipped pixel goes from accept through the write and done states to
//   rsp_valid. A searched pixel also scores candidates nd..0, nd =
//   min(max_disparity, MAX_DISP_DEPTH-1): one history read per candidate
//   through a single-port row memory, and the history write comes first.
//   A new word is taken only in the idle state, after the last result is
//   built; the next word is taken as soon as the result register is
//   free or being drained in the same cycle.
// Reset:
//   Counters go to zero, registers to their defaults. History holds junk
//   until written; raster order never reads an unwritten slot.
// Stall:
//   A held result keeps rsp_data steady; req_ready stays low until it goes.
// ---------------------------------------------------------------------------
`default_nettype none
module descriptor_sad_disparity_search #(
   parameter int MAX_DISP_DEPTH = dsds_pkg::MAX_DISP_DEPTH_DEF,
   parameter int DESC_BYTES     = dsds_pkg::DESC_BYTES_DEF,
   parameter int COORD_BITS     = dsds_pkg::COORD_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire dsds_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output dsds_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [dsds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dsds_pkg::CSR_DATA_W-1:0]   csr_data
);
   import dsds_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   dsds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dsds_datapath #(
      .MAX_DISP_DEPTH (MAX_DISP_DEPTH),
      .DESC_BYTES     (DESC_BYTES),
      .COORD_BITS     (COORD_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // a result is valid in the cycle after finish
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finish without result");
   // no new word is taken while the pipeline is mid-search
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.score || cmd.write) |-> !req_ready)
      else $error("accept during search");
   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed under stall");
`endif
endmodule
`default_nettype wire

// File: hdl/dsds_ctrl.sv
// ---------------------------------------------------------------------------
// dsds_ctrl: sequencer for the disparity search
// Accepts a word, writes history, steps one candidate per cycle through a
// read/score pipeline, then holds the result until taken.
// ---------------------------------------------------------------------------
`default_nettype none
module dsds_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire dsds_pkg::sts_type   sts,
   output dsds_pkg::cmd_type        cmd
);
   import dsds_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            // output register holds at most one word; accept when it is free or being drained
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // history is written before reads so the d = 0 slot sees this word
            cmd.write = 1'b1;
            state_in  = sts.search ? ST_READ : ST_DONE;
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_SCORE;
         end
         ST_SCORE: begin
            cmd.score = 1'b1;
            if (sts.last_cand) begin
               state_in = ST_DONE;
            end else begin
               cmd.rd_issue = 1'b1;
            end
         end
         ST_DONE: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

// File: hdl/dsds_datapath.sv
// ---------------------------------------------------------------------------
// dsds_datapath: history memory, SAD unit, winner compare, counters, CSRs
// ---------------------------------------------------------------------------
`default_nettype none
module dsds_datapath #(
   parameter int MAX_DISP_DEPTH = dsds_pkg::MAX_DISP_DEPTH_DEF,
   parameter int DESC_BYTES     = dsds_pkg::DESC_BYTES_DEF,
   parameter int COORD_BITS     = dsds_pkg::COORD_BITS_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire dsds_pkg::req_type                        req_data,
   input  wire logic                                     csr_valid,
   input  wire logic [dsds_pkg::CSR_IDX_W-1:0]           csr_index,
   input  wire logic [dsds_pkg::CSR_DATA_W-1:0]          csr_data,
   input  wire dsds_pkg::cmd_type                        cmd,
   output dsds_pkg::sts_type                             sts,
   output dsds_pkg::rsp_type                             rsp_data
);
   import dsds_pkg::*;

   localparam int SLOT_W   = $clog2(MAX_DISP_DEPTH);
   localparam int CMP_B    = (DESC_BYTES > 32) ? 32 : DESC_BYTES;
   localparam int ND_MAX   = MAX_DISP_DEPTH - 1;
   localparam int DIFF_W   = (DISP_W > SLOT_W) ? DISP_W : SLOT_W;
   localparam int X_W      = (COORD_BITS > LIM_W) ? COORD_BITS : LIM_W;
   localparam int CX_W     = (X_W > DIM_W) ? X_W + 1 : DIM_W + 1;
   localparam logic [CX_W-1:0] COORD_MAX = CX_W'((1 << COORD_BITS) - 1);

   // configuration registers
   logic [DISP_W-1:0] max_disp_ff;
   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [LIM_W-1:0]  first_col_ff, last_col_ff, first_row_ff, last_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_disp_ff  <= DISP_W'(40);
         width_ff     <= DIM_W'(640);
         height_ff    <= DIM_W'(480);
         first_col_ff <= LIM_W'(31);
         last_col_ff  <= LIM_W'(608);
         first_row_ff <= LIM_W'(31);
         last_row_ff  <= LIM_W'(448);
      end else if (csr_valid) begin
         case (csr_index)
            REG_MAX_DISP:   max_disp_ff  <= csr_data[DISP_W-1:0];
            REG_IMG_WIDTH:  width_ff     <= csr_data[DIM_W-1:0];
            REG_IMG_HEIGHT: height_ff    <= csr_data[DIM_W-1:0];
            REG_FIRST_COL:  first_col_ff <= csr_data[LIM_W-1:0];
            REG_LAST_COL:   last_col_ff  <= csr_data[LIM_W-1:0];
            REG_FIRST_ROW:  first_row_ff <= csr_data[LIM_W-1:0];
            REG_LAST_ROW:   last_row_ff  <= csr_data[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // raster counters
   logic [COORD_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic                  eoi_in;
   logic [CX_W-1:0]       nx, ny;

   always_comb begin
      nx     = CX_W'(col_ff) + CX_W'(1);
      ny     = CX_W'(row_ff) + CX_W'(1);
      col_in = col_ff;
      row_in = row_ff;
      eoi_in = 1'b0;
      if (nx >= CX_W'(width_ff) || nx > COORD_MAX) begin
         col_in = '0;
         if (ny >= CX_W'(height_ff) || ny > COORD_MAX) begin
            row_in = '0;
            eoi_in = 1'b1;
         end else begin
            row_in = ny[COORD_BITS-1:0];
         end
      end else begin
         col_in = nx[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.finish) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // captured word and search setup
   req_type             word_ff;
   logic                search_ff, search_in;
   logic [DIFF_W-1:0]   d_ff, nd_in;

   always_comb begin
      logic [X_W:0] xx, ndx;
      xx    = (X_W+1)'(col_ff);
      nd_in = (DIFF_W'(max_disp_ff) > DIFF_W'(ND_MAX)) ? DIFF_W'(ND_MAX)
                                                       : DIFF_W'(max_disp_ff);
      ndx   = (X_W+1)'(nd_in);
      search_in = (xx > (X_W+1)'(max_disp_ff)) && (xx >= (X_W+1)'(first_col_ff))
               && (xx <= (X_W+1)'(last_col_ff))
               && ((X_W+1)'(row_ff) >= (X_W+1)'(first_row_ff))
               && ((X_W+1)'(row_ff) <= (X_W+1)'(last_row_ff))
               && (xx - ndx >= (X_W+1)'(first_col_ff));
   end

   // history memory: one 4-word row per slot
   logic [WORDS*64-1:0] hist_mem [MAX_DISP_DEPTH];
   logic [WORDS*64-1:0] rd_data_ff;
   logic [DIFF_W-1:0]   rd_d_ff;
   logic [SLOT_W-1:0]   rd_slot;

   assign rd_slot = SLOT_W'(col_ff) - SLOT_W'(d_ff);

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         hist_mem[SLOT_W'(col_ff)] <= {word_ff.right_desc_w3, word_ff.right_desc_w2,
                                       word_ff.right_desc_w1, word_ff.right_desc_w0};
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= hist_mem[rd_slot];
         rd_d_ff    <= d_ff;
      end
   end

   // SAD of registered read row
   logic [COST_W-1:0]   sad;
   logic [WORDS*64-1:0] lft;

   assign lft = {word_ff.left_desc_w3, word_ff.left_desc_w2,
                 word_ff.left_desc_w1, word_ff.left_desc_w0};

   always_comb begin
      logic [7:0]        a, b;
      logic [COST_W-1:0] part [32];
      for (int k = 0; k < 32; k++) begin
         a       = lft[k*8 +: 8];
         b       = rd_data_ff[k*8 +: 8];
         part[k] = (k < CMP_B) ? COST_W'((a > b) ? a - b : b - a) : '0;
      end
      // byte lanes summed by a pairwise tree, five levels deep
      for (int n = 16; n > 0; n = n >> 1) begin
         for (int k = 0; k < n; k++) begin
            part[k] = part[2*k] + part[2*k+1];
         end
      end
      sad = part[0];
   end

   // winner track: strict less keeps earlier (larger) disparity on ties
   logic              have_ff;
   logic [COST_W-1:0] best_ff;
   logic [DIFF_W-1:0] best_d_ff;
   rsp_type           rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff   <= req_data;
         have_ff   <= 1'b0;
      end
      if (cmd.write) begin
         search_ff <= search_in;
         d_ff      <= nd_in;
      end
      if (cmd.rd_issue && !cmd.write) begin
         d_ff <= d_ff - DIFF_W'(1);
      end
      if (cmd.score) begin
         if (!have_ff || sad < best_ff) begin
            best_ff   <= sad;
            best_d_ff <= rd_d_ff;
         end
         have_ff <= 1'b1;
      end
      if (cmd.finish) begin
         if (search_ff && best_ff != '0) begin
            rsp_ff.disparity <= DISP_W'(best_d_ff);
            rsp_ff.min_cost  <= best_ff;
         end else begin
            rsp_ff.disparity <= '0;
            rsp_ff.min_cost  <= '0;
         end
         rsp_ff.end_of_image <= eoi_in;
      end
   end

   assign sts.search    = search_in;
   assign sts.last_cand = (rd_d_ff == '0);
   assign rsp_data      = rsp_ff;
endmodule
`default_nettype wire

// File: sim/descriptor_sad_disparity_search_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// descriptor_sad_disparity_search_tb: self-checking bench for the SAD search
// Streams raster-order pixel words with random gaps and output stalls, scores
// every word with an in-bench SAD winner-take-all predictor and compares each
// result word field by field. Register settings change between idle phases.
// ---------------------------------------------------------------------------
module descriptor_sad_disparity_search_tb;
   import dsds_pkg::*;

   localparam int HIST_DEPTH = 64;
   localparam int HIST_MAX   = HIST_DEPTH - 1;
   localparam int WD_LIMIT   = 4000;   // idle cycles before the watchdog fires
   localparam int LONG_HOLD  = 400;    // long output stall, fills the block

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   descriptor_sad_disparity_search dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---- predictor state: own copy of registers, counters and row history
   logic [63:0] right_rows [HIST_DEPTH][WORDS];
   int unsigned col_pos, row_pos;
   int unsigned cfg_ndisp, cfg_width, cfg_height;
   int unsigned cfg_col_lo, cfg_col_hi, cfg_row_lo, cfg_row_hi;

   rsp_type     disp_expected [$];
   int          mismatches = 0;
   int          words_sent = 0, words_checked = 0, searched = 0, frames = 0;
   bit          no_gaps = 1'b0;     // stretches with no idling on either side
   bit          hold_once = 1'b0;   // receiver takes one long stall
   logic [63:0] recent_right [$];   // stimulus side: recent right descriptors

   function automatic int unsigned byte_sad(input logic [63:0] a [WORDS],
                                            input logic [63:0] b [WORDS]);
      int unsigned sum;
      int unsigned x, y;
      sum = 0;
      for (int k = 0; k < 32; k++) begin
         x = a[k/8][(k%8)*8 +: 8];
         y = b[k/8][(k%8)*8 +: 8];
         sum += (x > y) ? x - y : y - x;
      end
      return sum;
   endfunction

   // Scores one accepted pixel word and steps the raster counters.
   function automatic rsp_type score_pixel(input req_type p);
      rsp_type     r;
      logic [63:0] lw [WORDS];
      int unsigned x, y, nd, best, best_d, c, nx, ny;
      bit          eoi;
      x = col_pos; y = row_pos;
      r = '0;
      lw[0] = p.left_desc_w0; lw[1] = p.left_desc_w1;
      lw[2] = p.left_desc_w2; lw[3] = p.left_desc_w3;
      right_rows[x % HIST_DEPTH][0] = p.right_desc_w0;
      right_rows[x % HIST_DEPTH][1] = p.right_desc_w1;
      right_rows[x % HIST_DEPTH][2] = p.right_desc_w2;
      right_rows[x % HIST_DEPTH][3] = p.right_desc_w3;
      if (x > cfg_ndisp && x >= cfg_col_lo && x <= cfg_col_hi &&
          y >= cfg_row_lo && y <= cfg_row_hi) begin
         searched++;
         nd = (cfg_ndisp > HIST_MAX) ? HIST_MAX : cfg_ndisp;
         // a candidate left of the rectangle forces 0
         if (x - nd >= cfg_col_lo) begin
            best = 32'hFFFF_FFFF; best_d = 0;
            // walk deepest first; strict less keeps ties at the larger d
            for (int d = nd; d >= 0; d--) begin
               c = byte_sad(lw, right_rows[(x - d) % HIST_DEPTH]);
               if (c < best) begin
                  best = c; best_d = d;
               end
            end
            if (best != 0) begin
               r.disparity = best_d[DISP_W-1:0];
               r.min_cost  = best[COST_W-1:0];
            end
         end
      end
      nx = x + 1; eoi = 1'b0; ny = y;
      if (nx >= cfg_width || nx > 4095) begin
         nx = 0; ny = y + 1;
         if (ny >= cfg_height || ny > 4095) begin
            ny = 0; eoi = 1'b1;
         end
      end
      col_pos = nx; row_pos = ny;
      r.end_of_image = eoi;
      return r;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] v);
      case (idx)
         REG_MAX_DISP:   cfg_ndisp  = 32'(v[5:0]);
         REG_IMG_WIDTH:  cfg_width  = 32'(v[12:0]);
         REG_IMG_HEIGHT: cfg_height = 32'(v[12:0]);
         REG_FIRST_COL:  cfg_col_lo = 32'(v[11:0]);
         REG_LAST_COL:   cfg_col_hi = 32'(v[11:0]);
         REG_FIRST_ROW:  cfg_row_lo = 32'(v[11:0]);
         REG_LAST_ROW:   cfg_row_hi = 32'(v[11:0]);
         default: ;
      endcase
   endfunction

   // Writes all seven registers back to back; valid stays high between them.
   task automatic write_regs(input int unsigned v [7]);
      logic [CSR_IDX_W-1:0] idx;
      for (int i = 0; i < 7; i++) begin
         idx = CSR_IDX_W'(i);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= CSR_DATA_W'(v[i]);
         do @(posedge clock); while (!csr_ready);
         apply_reg(idx, CSR_DATA_W'(v[i]));
      end
      csr_valid <= 1'b0;
   endtask

   // Offers one pixel word; valid is only dropped when a gap follows.
   task automatic send_pixel(input req_type p, input bit typed, input rsp_type want);
      int gap;
      rsp_type pred;
      gap = no_gaps ? 0 : $urandom_range(15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
      pred = score_pixel(p);
      disp_expected.insert(disp_expected.size(), typed ? want : pred);
      words_sent++;
   endtask

   // Waits for the pipeline to drain, then lets the block settle.
   task automatic drain;
      req_valid <= 1'b0;
      while (disp_expected.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Left descriptor is mostly a lightly disturbed copy of a recent right
   // descriptor, so scores stay small and zero scores and ties show up.
   function automatic req_type make_pixel();
      req_type     p;
      logic [63:0] w [WORDS];
      int          d, n, k;
      p = {rand64(), rand64(), rand64(), rand64(),
           rand64(), rand64(), rand64(), rand64()};
      if ($urandom_range(9) == 0 && recent_right.size() >= WORDS) begin
         // repeated right descriptor gives equal scores
         p.right_desc_w0 = recent_right[0]; p.right_desc_w1 = recent_right[1];
         p.right_desc_w2 = recent_right[2]; p.right_desc_w3 = recent_right[3];
      end
      if ($urandom_range(9) != 0 && recent_right.size() >= WORDS) begin
         d = $urandom_range(recent_right.size() / WORDS - 1);
         for (int i = 0; i < WORDS; i++) w[i] = recent_right[d*WORDS + i];
         n = $urandom_range(3);
         for (int i = 0; i < n; i++) begin
            k = $urandom_range(31);
            w[k/8][(k%8)*8 +: 8] = w[k/8][(k%8)*8 +: 8] + 8'($urandom_range(1, 4));
         end
         p.left_desc_w0 = w[0]; p.left_desc_w1 = w[1];
         p.left_desc_w2 = w[2]; p.left_desc_w3 = w[3];
      end
      recent_right.push_front(p.right_desc_w3);
      recent_right.push_front(p.right_desc_w2);
      recent_right.push_front(p.right_desc_w1);
      recent_right.push_front(p.right_desc_w0);
      while (recent_right.size() > HIST_DEPTH * WORDS) void'(recent_right.pop_back());
      return p;
   endfunction

   // ---- result side: random stalls, one long hold on request
   initial begin
      int      stall;
      rsp_type want;
      @(negedge reset);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(15);
         if (hold_once) begin
            stall = LONG_HOLD;
            hold_once = 1'b0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         words_checked++;
         if (rsp_data.end_of_image) frames++;
         if (disp_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: %p", rsp_data);
         end else begin
            want = disp_expected.pop_front();
            if (rsp_data.disparity !== want.disparity ||
                rsp_data.min_cost !== want.min_cost ||
                rsp_data.end_of_image !== want.end_of_image) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch word %0d: exp disp %0d cost %0d eoi %0b,",
                            " got disp %0d cost %0d eoi %0b"},
                           words_checked, want.disparity, want.min_cost,
                           want.end_of_image, rsp_data.disparity,
                           rsp_data.min_cost, rsp_data.end_of_image);
            end
         end
      end
   end

   // ---- watchdog: cycles with no handshake on any channel
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WD_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ---- stimulus
   typedef struct {
      req_type px;
      bit      typed;
      rsp_type want;
   } vector_row;

   initial begin
      vector_row    vectors [$];
      vector_row    row;
      int unsigned  phase_regs [6][7];
      int           phase_len [6];
      logic [63:0]  pat;

      cfg_ndisp = 40; cfg_width = 640; cfg_height = 480;
      cfg_col_lo = 31; cfg_col_hi = 608; cfg_row_lo = 31; cfg_row_hi = 448;
      col_pos = 0; row_pos = 0;
      foreach (right_rows[i, j]) right_rows[i][j] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Defaults: row 0 lies above the rectangle, so results are plain zero.
      for (int i = 0; i < 3; i++) begin
         row.px = '1; row.typed = 1'b1; row.want = '0;
         if (i == 1) row.px = '0;
         vectors.insert(vectors.size(), row);
      end
      foreach (vectors[i]) send_pixel(vectors[i].px, 1'b1, vectors[i].want);
      drain();

      // Tiny 8x2 image, depth 2, rectangle starting at column 2: the first
      // searched column reaches left of the rectangle and is forced to 0.
      write_regs('{2, 8, 2, 2, 7, 0, 1});
      vectors.delete();
      for (int i = 0; i < 13; i++) begin
         row.typed = 1'b0; row.want = '0;
         case (i % 5)
            0: pat = '0;
            1: pat = '1;
            2: pat = {8{8'h55}};
            3: pat = {8{8'hAA}};
            default: pat = rand64();
         endcase
         row.px = {pat, pat, pat, pat, ~pat, ~pat, ~pat, ~pat};
         if (i % 3 == 1) row.px[255:0] = row.px[511:256];  // zero score
         if (i % 3 == 2) row.px[511:256] = '0;             // heavy cost
         vectors.insert(vectors.size(), row);
      end
      foreach (vectors[i]) send_pixel(vectors[i].px, 1'b0, '0);
      drain();

      // Random phases, each from idle; columns restart in a new row.
      phase_regs = '{'{0,  1,    1,    0,    0,    0,    0},
                     '{63, 100,  3,    0,    4095, 0,    4095},
                     '{8,  24,   5,    3,    20,   1,    3},
                     '{40, 4096, 4096, 4095, 4095, 4095, 4095},
                     '{15, 40,   3,    5,    35,   0,    2},
                     '{3,  12,   13,   2,    10,   0,    4095}};
      phase_len = '{40, 220, 150, 40, 160, 140};
      for (int ph = 0; ph < 6; ph++) begin
         write_regs(phase_regs[ph]);
         no_gaps = (ph == 4);
         for (int i = 0; i < phase_len[ph]; i++) begin
            // long output hold while input keeps coming: input must stall
            if (ph == 2 && i == 20) hold_once = 1'b1;
            send_pixel(make_pixel(), 1'b0, '0);
         end
         no_gaps = 1'b0;
         drain();
      end

      $display("%0d pixel words sent, %0d results checked, %0d searched, %0d frame ends",
               words_sent, words_checked, searched, frames);
      $display("covered depths 0..63, widths 1..4096, forced-zero and tie cases");
      if (mismatches == 0 && disp_expected.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
